/* rtl/wildcard_mask_name_filter_defines.svh */
// Assertion macros shared by the RTL of the wildcard mask name filter.
`ifndef WILDCARD_MASK_NAME_FILTER_DEFINES_SVH
`define WILDCARD_MASK_NAME_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define WMNF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define WMNF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WMNF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define WMNF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/wmnf_pkg.sv */
`default_nettype none

package wmnf_pkg;

  // Field widths of the request and configuration port
  localparam int SLOT_W     = 3;
  localparam int POS_W      = 6;
  localparam int CODE_W     = 8;
  localparam int COUNT_W    = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IGNORE_CASE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INCLUDE_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_EXCLUDE_COUNT = 2'd2;

  // Request kinds and banks
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_NAME    = 1'b1;
  localparam logic BANK_INCLUDE = 1'b0;
  localparam logic BANK_EXCLUDE = 1'b1;

  // Special mask characters
  localparam logic [CODE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CODE_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CODE_W-1:0] CHAR_QMARK = 8'h3F;

  // Command broadcast to every mask lane
  typedef struct packed {
    logic load;   // write one mask character or end marker
    logic step;   // advance the position set by one name byte
    logic start;  // the byte opens a new name
    logic fold;   // compare letters without case
  } lane_cmd_t;

  // Result of one name
  typedef struct packed {
    logic included;
    logic excluded;
    logic listed;
  } result_t;

endpackage

`default_nettype wire

/* rtl/wmnf_mask_lane.sv */
`default_nettype none

module wmnf_mask_lane #(
  parameter int MASK_LEN = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wmnf_pkg::lane_cmd_t         cmd,
  input  wire                         load_sel,
  input  wire  [wmnf_pkg::POS_W-1:0]  pos,
  input  wire  [wmnf_pkg::CODE_W-1:0] code,
  output logic                        match
);
  import wmnf_pkg::*;

  localparam int IW     = (MASK_LEN > 1) ? $clog2(MASK_LEN) : 1;
  localparam int LW     = $clog2(MASK_LEN + 1);
  localparam int LEVELS = $clog2(MASK_LEN + 1);

  logic [CODE_W-1:0] chars_r [MASK_LEN];
  logic [LW-1:0]     len_r, len_nxt;
  logic [MASK_LEN:0] act_r, act_nxt;

  logic [MASK_LEN-1:0] in_len, star, hit;
  logic [MASK_LEN:0]   start_set, base, stepped;
  logic                name_letter;
  logic [CODE_W-1:0]   name_low;

  function automatic logic is_letter(input logic [CODE_W-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic [CODE_W-1:0] to_lower(input logic [CODE_W-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c | 8'h20) : c;
  endfunction

  // Spread live positions across runs of '*' (segmented prefix OR, log depth)
  function automatic logic [MASK_LEN:0] close_stars(input logic [MASK_LEN:0] set_in,
                                                    input logic [MASK_LEN-1:0] stars);
    logic [MASK_LEN:0] g, p, g_n, p_n;
    int d;
    int lv;
    int i;
    g = set_in;
    p = {stars, 1'b0};
    for (lv = 0; lv < LEVELS; lv++) begin
      d   = 1 << lv;
      g_n = g;
      p_n = p;
      for (i = 0; i <= MASK_LEN; i++) begin
        if (i >= d) begin
          g_n[i] = g[i] | (p[i] & g[i-d]);
          p_n[i] = p[i] & p[i-d];
        end else begin
          p_n[i] = 1'b0;
        end
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

  // Classify every mask position against the incoming byte
  always_comb begin
    name_letter = is_letter(code);
    name_low    = to_lower(code);
    for (int i = 0; i < MASK_LEN; i++) begin
      in_len[i] = (LW'(i) < len_r);
      star[i]   = in_len[i] && (chars_r[i] == CHAR_STAR);
      if (cmd.fold && name_letter && is_letter(chars_r[i])) begin
        hit[i] = in_len[i] && (to_lower(chars_r[i]) == name_low);
      end else begin
        hit[i] = in_len[i] && ((chars_r[i] == CHAR_QMARK) || (chars_r[i] == code));
      end
    end
  end

  // Advance the position set by one byte
  always_comb begin
    start_set = close_stars({{MASK_LEN{1'b0}}, 1'b1}, star);
    base      = cmd.start ? start_set : act_r;
    stepped   = '0;
    for (int i = 0; i < MASK_LEN; i++) begin
      if (base[i] && star[i]) begin
        stepped[i] = 1'b1;
      end
      if (base[i] && !star[i] && hit[i]) begin
        stepped[i+1] = 1'b1;
      end
    end
    act_nxt = close_stars(stepped, star);
    match   = act_nxt[len_r];
  end

  // Length update on loads
  always_comb begin
    len_nxt = len_r;
    if (code == CHAR_NUL) begin
      len_nxt = LW'(pos);
    end else if ((int'(pos) < MASK_LEN) && (LW'(pos) == len_r)) begin
      len_nxt = LW'(pos) + LW'(1);
    end
  end

  // Hold length and live positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      act_r <= '0;
    end else begin
      if (cmd.load && load_sel) begin
        len_r <= len_nxt;
      end
      if (cmd.step) begin
        act_r <= act_nxt;
      end
    end
  end

  // Store mask characters
  always_ff @(posedge clk) begin
    if (cmd.load && load_sel && (code != CHAR_NUL) && (int'(pos) < MASK_LEN)) begin
      chars_r[IW'(pos)] <= code;
    end
  end

endmodule

`default_nettype wire

/* rtl/wmnf_out_reg.sv */
`default_nettype none

module wmnf_out_reg (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  wmnf_pkg::result_t   din,
  input  wire                 out_ready,
  output logic                out_valid,
  output wmnf_pkg::result_t   dout,
  output logic                free
);
  import wmnf_pkg::*;

  logic    valid_r;
  result_t data_r;

  // Room for a new result when empty or being drained this cycle
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign dout      = data_r;

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

endmodule

`default_nettype wire

/* rtl/wildcard_mask_name_filter.sv */
// Wildcard mask name filter. Two banks of MASKS_PER_BANK masks (include,
// exclude) of up to MASK_LEN characters are loaded one character per
// request; a zero character sets the mask length. Names stream one byte per
// request, and every mask advances its set of live pattern positions on each
// byte, so one request is taken every cycle as long as the result sink keeps
// up. A request is registered at acceptance and processed in the next cycle;
// the result of a name is loaded into the output register at the edge at
// which its last byte leaves the input register, which is the edge right
// after acceptance unless the output register is full and not being drained.
// Only a full output register that is not being drained stalls the input. The
// cycle time is set by the per-position compare and the two log-depth '*'
// closure networks of each mask lane. No clearing pass follows reset.
`default_nettype none

`include "wildcard_mask_name_filter_defines.svh"

module wildcard_mask_name_filter #(
  parameter int MASKS_PER_BANK = 8,
  parameter int MASK_LEN       = 32
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // bank[0], mask_slot[3:1], char_position[9:4], char_code[17:10]
  input  wire  [wmnf_pkg::IN_DATA_W-1:0]        in_tdata,
  // func
  input  wire                                   in_tuser,
  input  wire                                   in_tlast,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // listed[0], excluded[1], included[2]
  output logic [wmnf_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  input  wire                                   cfg_we,
  input  wire  [wmnf_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire  [wmnf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import wmnf_pkg::*;

  localparam int NUM_MASKS = 2 * MASKS_PER_BANK;

  // Configuration registers
  logic               ign_r;
  logic [COUNT_W-1:0] inc_cnt_r, exc_cnt_r;

  // Input register
  logic              stg_v_r;
  logic              stg_func_r, stg_bank_r, stg_last_r;
  logic [SLOT_W-1:0] stg_slot_r;
  logic [POS_W-1:0]  stg_pos_r;
  logic [CODE_W-1:0] stg_code_r;

  logic      at_start_r;
  logic      needs_out, adv, load_ok, out_free;
  lane_cmd_t cmd;
  logic [NUM_MASKS-1:0] lane_sel, match;
  logic      inc_hit, exc_hit;
  result_t   res, res_out;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ign_r     <= 1'b0;
      inc_cnt_r <= '0;
      exc_cnt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IGNORE_CASE:   ign_r     <= cfg_wdata[0];
        REG_INCLUDE_COUNT: inc_cnt_r <= cfg_wdata;
        REG_EXCLUDE_COUNT: exc_cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the held request unless its result has nowhere to go
  assign needs_out = (stg_func_r == FUNC_NAME) && stg_last_r;
  assign adv       = stg_v_r && (!needs_out || out_free);
  assign in_tready = !stg_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_tready) begin
      stg_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_func_r <= in_tuser;
      stg_bank_r <= in_tdata[0];
      stg_slot_r <= in_tdata[3:1];
      stg_pos_r  <= in_tdata[9:4];
      stg_code_r <= in_tdata[17:10];
      stg_last_r <= in_tlast;
    end
  end

  // Track name boundaries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
    end else if (adv && (stg_func_r == FUNC_NAME)) begin
      at_start_r <= stg_last_r;
    end
  end

  // Drop loads that fall outside the mask store
  assign load_ok = (stg_func_r == FUNC_LOAD) && (int'(stg_slot_r) < MASKS_PER_BANK) &&
                   (int'(stg_pos_r) <= MASK_LEN);

  assign cmd.load  = adv && load_ok;
  assign cmd.step  = adv && (stg_func_r == FUNC_NAME);
  assign cmd.start = at_start_r;
  assign cmd.fold  = ign_r;

  // Mask lanes, include bank first
  for (genvar g = 0; g < NUM_MASKS; g++) begin : g_lane
    localparam logic LANE_BANK = (g >= MASKS_PER_BANK) ? BANK_EXCLUDE : BANK_INCLUDE;
    localparam int   LANE_SLOT = g % MASKS_PER_BANK;

    assign lane_sel[g] = (stg_bank_r == LANE_BANK) && (int'(stg_slot_r) == LANE_SLOT);

    wmnf_mask_lane #(
      .MASK_LEN (MASK_LEN)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .load_sel (lane_sel[g]),
      .pos      (stg_pos_r),
      .code     (stg_code_r),
      .match    (match[g])
    );
  end

  // Combine matches of the masks in use
  always_comb begin
    inc_hit = 1'b0;
    exc_hit = 1'b0;
    for (int k = 0; k < MASKS_PER_BANK; k++) begin
      if (k < int'(inc_cnt_r)) begin
        inc_hit = inc_hit | match[k];
      end
      if (k < int'(exc_cnt_r)) begin
        exc_hit = exc_hit | match[MASKS_PER_BANK + k];
      end
    end
    res.included = inc_hit;
    res.excluded = exc_hit;
    res.listed   = inc_hit && !exc_hit;
  end

  wmnf_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && needs_out),
    .din       (res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .dout      (res_out),
    .free      (out_free)
  );

  assign out_tdata = {{(OUT_DATA_W - 3){1'b0}}, res_out.included, res_out.excluded,
                      res_out.listed};

  // Checks
  `WMNF_ASSERT_IMPL(a_listed_consistent, clk, rst_n, out_tvalid,
                    out_tdata[0] == (out_tdata[2] && !out_tdata[1]),
                    "listed disagrees with included and excluded")
  `WMNF_ASSERT_IMPL(a_stall_only_on_result, clk, rst_n, stg_v_r && !adv,
                    needs_out && out_tvalid && !out_tready,
                    "input register stalled without a blocked result")
  `WMNF_ASSERT_IMPL(a_accept_full_moves, clk, rst_n, in_tvalid && in_tready && stg_v_r,
                    adv, "request accepted over a held request")
  `WMNF_ASSERT_NEXT(a_name_end_restarts, clk, rst_n, cmd.step && stg_last_r,
                    at_start_r && out_tvalid, "name end did not restart or report")

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import wmnf_pkg::*;

  localparam int MASKS_PER_BANK = 8;
  localparam int MASK_LEN       = 32;
  localparam int NUM_MASKS      = 2 * MASKS_PER_BANK;

  typedef logic [CODE_W-1:0] byte_q_t[$];

  // One request as the testbench sees it
  typedef struct packed {
    logic              func;
    logic              bank;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic [CODE_W-1:0] code;
    logic              last;
  } request_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  in_tlast;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wildcard_mask_name_filter #(
    .MASKS_PER_BANK(MASKS_PER_BANK),
    .MASK_LEN      (MASK_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the filter: mask contents, lengths and live position sets
  bit [CODE_W-1:0] mask_text [NUM_MASKS][MASK_LEN];
  bit              char_loaded [NUM_MASKS][MASK_LEN];
  bit [POS_W-1:0]  mask_len [NUM_MASKS];
  bit [MASK_LEN:0] live_pos [NUM_MASKS];
  bit              name_start = 1'b1;
  bit              fold_case;
  bit [3:0]        include_cnt;
  bit [3:0]        exclude_cnt;

  result_t pending_results[$];
  int      mismatches;
  int      items_sent;
  bit      quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Extend a position set through runs of '*' that consume no byte
  function automatic bit [MASK_LEN:0] close_stars(input int m, input bit [MASK_LEN:0] s);
    for (int i = 0; i < mask_len[m]; i++)
      if (s[i] && mask_text[m][i] == CHAR_STAR) s[i+1] = 1'b1;
    return s;
  endfunction

  function automatic bit is_letter(input logic [CODE_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit chars_equal(input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b);
    if (fold_case && is_letter(a) && is_letter(b)) return (a | 8'h20) == (b | 8'h20);
    return a == b;
  endfunction

  function automatic bit bank_hit(input int base, input int cnt);
    int n;
    n = (cnt > MASKS_PER_BANK) ? MASKS_PER_BANK : cnt;
    for (int k = 0; k < n; k++)
      if (live_pos[base+k][mask_len[base+k]]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int written_prefix(input int m);
    int n;
    n = 0;
    while (n < MASK_LEN && char_loaded[m][n]) n++;
    return n;
  endfunction

  // Apply one request to the mirror; return 1 with the result on a last name byte
  function automatic bit filter_request(input request_t r, output result_t res);
    bit [MASK_LEN:0] nxt;
    int              m;
    bit              inc;
    bit              exc;
    res = '0;
    if (r.func == FUNC_LOAD) begin
      if (r.pos > MASK_LEN) return 1'b0;
      m = int'(r.bank) * MASKS_PER_BANK + int'(r.slot);
      if (r.code == CHAR_NUL) begin
        mask_len[m] = r.pos;
      end else if (r.pos < MASK_LEN) begin
        mask_text[m][r.pos] = r.code;
        char_loaded[m][r.pos] = 1'b1;
        if (r.pos == mask_len[m]) mask_len[m] = POS_W'(r.pos + 1);
      end
      return 1'b0;
    end
    if (name_start)
      for (int k = 0; k < NUM_MASKS; k++)
        live_pos[k] = close_stars(k, (MASK_LEN+1)'(1));
    for (int k = 0; k < NUM_MASKS; k++) begin
      nxt = '0;
      for (int i = 0; i < mask_len[k]; i++) begin
        if (!live_pos[k][i]) continue;
        if (mask_text[k][i] == CHAR_STAR) nxt[i] = 1'b1;
        else if (mask_text[k][i] == CHAR_QMARK || chars_equal(r.code, mask_text[k][i]))
          nxt[i+1] = 1'b1;
      end
      live_pos[k] = close_stars(k, nxt);
    end
    name_start = r.last;
    if (!r.last) return 1'b0;
    inc = bank_hit(0, int'(include_cnt));
    exc = bank_hit(MASKS_PER_BANK, int'(exclude_cnt));
    res.included = inc;
    res.excluded = exc;
    res.listed   = inc && !exc;
    return 1'b1;
  endfunction

  // Send one request, with an occasional gap before it
  task automatic push_request(input request_t r);
    result_t want;
    int      m;
    // keep a zero load from ending a mask past characters never written
    if (r.func == FUNC_LOAD && r.code == CHAR_NUL && r.pos <= MASK_LEN) begin
      m = int'(r.bank) * MASKS_PER_BANK + int'(r.slot);
      if (r.pos > written_prefix(m)) r.pos = POS_W'(written_prefix(m));
    end
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tdata  <= {{(IN_DATA_W-18){1'b0}}, r.code, r.pos, r.slot, r.bank};
    in_tuser  <= r.func;
    in_tlast  <= r.last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (filter_request(r, want)) pending_results.push_back(want);
    items_sent++;
  endtask

  task automatic load_char(input logic bank, input int slot, input int pos,
                           input logic [CODE_W-1:0] code);
    request_t r;
    r = '{func: FUNC_LOAD, bank: bank, slot: SLOT_W'(slot), pos: POS_W'(pos),
          code: code, last: 1'($urandom_range(0, 1))};
    push_request(r);
  endtask

  // Write a whole mask, then its end marker
  task automatic load_mask(input logic bank, input int slot, input byte_q_t text);
    foreach (text[i]) load_char(bank, slot, i, text[i]);
    load_char(bank, slot, text.size(), CHAR_NUL);
  endtask

  // Stream a name; noise_pct mixes random loads in between its bytes
  task automatic send_name(input byte_q_t text, input int noise_pct);
    request_t r;
    foreach (text[i]) begin
      if (i > 0 && $urandom_range(0, 99) < noise_pct)
        load_char(1'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom_range(0, 63),
                  ($urandom_range(0, 3) == 0) ? CHAR_NUL : CODE_W'($urandom_range(1, 255)));
      r = '{func: FUNC_NAME, bank: 1'($urandom_range(0, 1)),
            slot: SLOT_W'($urandom_range(0, 7)), pos: POS_W'($urandom_range(0, 63)),
            code: text[i], last: (i == text.size() - 1)};
      push_request(r);
    end
  endtask

  // Hold off until every result is back, plus the pipeline depth
  task automatic wait_results_drained;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers; call only while idle
  task automatic write_regs(input bit fold, input logic [3:0] inc, input logic [3:0] exc);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_IGNORE_CASE;
    cfg_wdata <= {3'($urandom_range(0, 7)), fold};
    @(posedge clk);
    cfg_addr  <= REG_INCLUDE_COUNT;
    cfg_wdata <= inc;
    @(posedge clk);
    cfg_addr  <= REG_EXCLUDE_COUNT;
    cfg_wdata <= exc;
    @(posedge clk);
    cfg_we <= 1'b0;
    fold_case   = fold;
    include_cnt = inc;
    exclude_cnt = exc;
  endtask

  function automatic byte_q_t to_bytes(input string s);
    byte_q_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic byte_q_t random_text(input bit for_name);
    byte_q_t         t;
    int              n;
    logic [CODE_W-1:0] ch;
    if ($urandom_range(0, 15) == 0) n = for_name ? $urandom_range(9, 40) : MASK_LEN;
    else n = for_name ? $urandom_range(1, 8) : $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: ch = CHAR_STAR;
        1: ch = CHAR_QMARK;
        2: ch = 8'h61;
        3: ch = 8'h62;
        4: ch = 8'h41;
        5: ch = 8'h42;
        6: ch = 8'h2E;
        default: ch = for_name ? CODE_W'($urandom_range(0, 255)) : CODE_W'($urandom_range(1, 255));
      endcase
      t.push_back(ch);
    end
    return t;
  endfunction

  function automatic logic [3:0] random_count();
    case ($urandom_range(0, 7))
      0, 1: return 4'd8;
      2:    return 4'd0;
      3:    return 4'($urandom_range(9, 15));
      default: return 4'($urandom_range(1, 8));
    endcase
  endfunction

  // Case folding, counts of zero and above the bank size, a zero name byte
  task automatic test_case_and_counts;
    byte_q_t nul_name;
    nul_name = '{CHAR_NUL};
    write_regs(1'b0, 4'd8, 4'd8);
    load_mask(BANK_INCLUDE, 0, to_bytes("a*"));
    load_mask(BANK_EXCLUDE, 7, to_bytes("?B"));
    send_name(to_bytes("ab"), 0);
    send_name(to_bytes("xB"), 0);
    wait_results_drained;
    write_regs(1'b1, 4'd15, 4'd8);
    send_name(to_bytes("AB"), 0);
    send_name(nul_name, 0);
    send_name('{8'hFF}, 0);
    wait_results_drained;
    write_regs(1'b1, 4'd0, 4'd0);
    send_name(to_bytes("ab"), 0);
    wait_results_drained;
  endtask

  // Loads out of range, and a mask rewritten in the middle of a name
  task automatic test_load_corners;
    request_t r;
    write_regs(1'b0, 4'd1, 4'd1);
    load_char(BANK_INCLUDE, 0, 33, CHAR_NUL);
    load_char(BANK_INCLUDE, 0, 63, 8'h7A);
    load_char(BANK_INCLUDE, 0, MASK_LEN, 8'h7A);
    send_name(to_bytes("a"), 0);
    r = '{func: FUNC_NAME, bank: BANK_INCLUDE, slot: '0, pos: '0, code: 8'h61, last: 1'b0};
    push_request(r);
    load_char(BANK_INCLUDE, 0, 1, CHAR_NUL);
    r.code = 8'h78;
    r.last = 1'b1;
    push_request(r);
    wait_results_drained;
  endtask

  // Random masks and names over many register settings
  task automatic test_random_traffic;
    while (items_sent < 440) begin
      wait_results_drained;
      write_regs(1'($urandom_range(0, 1)), random_count(), random_count());
      repeat ($urandom_range(1, 4))
        load_mask(1'($urandom_range(0, 1)), $urandom_range(0, 7), random_text(1'b0));
      repeat ($urandom_range(4, 12)) send_name(random_text(1'b1), 12);
    end
  endtask

  // Back-to-back requests with the sink always ready
  task automatic test_full_rate;
    quiet = 1'b1;
    wait_results_drained;
    write_regs(1'b1, 4'd8, 4'd8);
    load_mask(BANK_INCLUDE, 3, random_text(1'b0));
    repeat (10) send_name(random_text(1'b1), 5);
  endtask

  // Sink side: random stall bursts, off once the run turns quiet
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(0, 19)) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[2:0]);
      if (pending_results.size() == 0) begin
        $error("unexpected result, out_tdata=%b", out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.listed !== want.listed) begin
          $error("listed: expected %0b, got %0b", want.listed, got.listed);
          mismatches++;
        end
        if (got.excluded !== want.excluded) begin
          $error("excluded: expected %0b, got %0b", want.excluded, got.excluded);
          mismatches++;
        end
        if (got.included !== want.included) begin
          $error("included: expected %0b, got %0b", want.included, got.included);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    in_tvalid <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_case_and_counts;
    test_load_corners;
    test_random_traffic;
    test_full_rate;
    wait_results_drained;
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
